// ===== design/decimal_int32_token_validator_core_defines.svh =====
// ----------------------------------------------------------------------------
// Decimal int32 token validator - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_INT32_TOKEN_VALIDATOR_CORE_DEFINES_SVH
`define DECIMAL_INT32_TOKEN_VALIDATOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define DTV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define DTV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dtv_pkg.sv =====
// ----------------------------------------------------------------------------
// Decimal int32 token validator - package
// Shared types, character codes and the int32 limit digit table.
// ----------------------------------------------------------------------------
`default_nettype none

package dtv_pkg;

    // Default saturation point of the token counter
    localparam int MAX_TOKENS_DEFAULT = 1023;

    localparam int CHAR_W  = 8;
    localparam int COUNT_W = 10;
    localparam int SIG_W   = 4;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    // Significant digit counts
    localparam logic [SIG_W-1:0] LIMIT_LEN = 4'd10;  // digits in the int32 limit
    localparam logic [SIG_W-1:0] LAST_POS  = 4'd9;   // position of the final digit
    localparam logic [SIG_W-1:0] SIG_OVER  = 4'd11;  // held once a token is too long

    // Running comparison against the limit
    typedef enum logic [1:0] {
        CMP_EQ = 2'd0,
        CMP_LT = 2'd1,
        CMP_GT = 2'd2
    } cmp_t;

    // One accepted input character
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last_token;
    } item_t;

    // One result item
    typedef struct packed {
        logic               token_ok;
        logic               list_ok;
        logic [COUNT_W-1:0] token_count;
        logic               list_end;
    } result_t;

    // Digit of 2147483647 at a position; 8 at the last position when negative
    function automatic logic [3:0] limit_digit(input logic [SIG_W-1:0] pos,
                                               input logic             neg);
        logic [3:0] d;
        case (pos)
            4'd0:    d = 4'd2;
            4'd1:    d = 4'd1;
            4'd2:    d = 4'd4;
            4'd3:    d = 4'd7;
            4'd4:    d = 4'd4;
            4'd5:    d = 4'd8;
            4'd6:    d = 4'd3;
            4'd7:    d = 4'd6;
            4'd8:    d = 4'd4;
            4'd9:    d = neg ? 4'd8 : 4'd7;
            default: d = 4'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== design/decimal_int32_token_validator_core.sv =====
// A terminator passes the input register, then the result register, to reach m_tvalid.
// Throughput: one character per cycle, set by the input register feeding the scanner
// and the single result register; m_tready low stalls only terminators.
// Reset (rst_n low, asynchronous): all token and list state cleared, both stages empty.
// ----------------------------------------------------------------------------
// Decimal int32 token validator - top level
// Checks a stream of NUL-terminated decimal tokens against the int32 range.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_int32_token_validator_core #(
    parameter int MAX_TOKENS = dtv_pkg::MAX_TOKENS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tlast,   // last_token
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [0] token_ok, [1] list_ok, [11:2] token_count
    output logic             m_tlast    // list_end
);

    logic             take;
    logic             item_valid;
    dtv_pkg::item_t   item;
    logic             res_valid;
    dtv_pkg::result_t res;
    logic             out_free;
    dtv_pkg::result_t m_res;

    dtv_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_ch       (s_tdata),
        .s_last     (s_tlast),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    dtv_scan #(
        .MAX_TOKENS (MAX_TOKENS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    dtv_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

    // Pack result fields
    assign m_tdata = {4'd0, m_res.token_count, m_res.list_ok, m_res.token_ok};
    assign m_tlast = m_res.list_end;

endmodule

`default_nettype wire

// ===== design/dtv_in_reg.sv =====
// ----------------------------------------------------------------------------
// Decimal int32 token validator - input register
// Holds one accepted character until the scanner consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dtv_in_reg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [dtv_pkg::CHAR_W-1:0]  s_ch,
    input  wire logic                        s_last,
    input  wire logic                        take,
    output logic                             item_valid,
    output dtv_pkg::item_t                   item
);

    logic            valid_reg;
    dtv_pkg::item_t  item_reg;

    // Free when empty or when the held character leaves this cycle
    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.ch         <= s_ch;
            item_reg.last_token <= s_last;
        end
    end

endmodule

`default_nettype wire

// ===== design/dtv_scan.sv =====
// ----------------------------------------------------------------------------
// Decimal int32 token validator - token scanner
// Per-character token state update and result generation on terminators.
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_int32_token_validator_core_defines.svh"

module dtv_scan #(
    parameter int MAX_TOKENS = dtv_pkg::MAX_TOKENS_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    input  wire dtv_pkg::item_t item,
    input  wire logic           out_free,
    output logic                take,
    output logic                res_valid,
    output dtv_pkg::result_t    res
);

    localparam logic [dtv_pkg::COUNT_W-1:0] COUNT_CAP =
        (MAX_TOKENS > 1023) ? 10'd1023 : dtv_pkg::COUNT_W'(MAX_TOKENS);

    logic                          first_reg,   first_next;
    logic                          neg_reg,     neg_next;
    logic                          lead_reg,    lead_next;
    logic                          bad_reg,     bad_next;
    logic [dtv_pkg::SIG_W-1:0]     sig_reg,     sig_next;
    dtv_pkg::cmp_t                 cmp_reg,     cmp_next;
    logic                          list_bad_reg, list_bad_next;
    logic [dtv_pkg::COUNT_W-1:0]   count_reg,   count_next;

    logic                          is_term;
    logic                          is_sign;
    logic                          is_digit;
    logic [3:0]                    digit;
    logic [3:0]                    lim;
    logic                          ok;

    assign is_term  = (item.ch == dtv_pkg::CHAR_NUL);
    assign is_sign  = (item.ch == dtv_pkg::CHAR_PLUS) || (item.ch == dtv_pkg::CHAR_MINUS);
    assign is_digit = (item.ch >= dtv_pkg::CHAR_ZERO) && (item.ch <= dtv_pkg::CHAR_NINE);
    assign digit    = item.ch[3:0];
    assign lim      = dtv_pkg::limit_digit(sig_reg, neg_reg);

    // A character always moves on; a terminator waits for the result slot
    assign take      = item_valid && (!is_term || out_free);
    assign res_valid = take && is_term;

    // Token verdict
    assign ok = !bad_reg &&
                ((sig_reg < dtv_pkg::LIMIT_LEN) ||
                 ((sig_reg == dtv_pkg::LIMIT_LEN) &&
                  ((cmp_reg == dtv_pkg::CMP_EQ) || (cmp_reg == dtv_pkg::CMP_LT))));

    // Next state and result
    always_comb
    begin
        first_next    = first_reg;
        neg_next      = neg_reg;
        lead_next     = lead_reg;
        bad_next      = bad_reg;
        sig_next      = sig_reg;
        cmp_next      = cmp_reg;
        list_bad_next = list_bad_reg;
        count_next    = count_reg;

        res.token_ok    = ok;
        res.list_ok     = !(list_bad_reg || !ok);
        res.token_count = (count_reg < COUNT_CAP) ? count_reg + 10'd1 : count_reg;
        res.list_end    = item.last_token;

        if (take)
        begin
            if (!is_term)
            begin
                first_next = 1'b0;
                if (first_reg && is_sign)
                begin
                    neg_next = (item.ch == dtv_pkg::CHAR_MINUS);
                end
                else if (is_digit)
                begin
                    // Leading zeros carry no weight
                    if (!(lead_reg && (digit == 4'd0)))
                    begin
                        lead_next = 1'b0;
                        if (sig_reg >= dtv_pkg::LIMIT_LEN)
                        begin
                            sig_next = dtv_pkg::SIG_OVER;
                        end
                        else
                        begin
                            if (cmp_reg == dtv_pkg::CMP_EQ)
                            begin
                                if (digit < lim)
                                begin
                                    cmp_next = dtv_pkg::CMP_LT;
                                end
                                else if (digit > lim)
                                begin
                                    cmp_next = dtv_pkg::CMP_GT;
                                end
                            end
                            sig_next = sig_reg + 4'd1;
                        end
                    end
                end
                else
                begin
                    bad_next = 1'b1;
                end
            end
            else
            begin
                // Token closes: clear token state, and list state on list end
                first_next = 1'b1;
                neg_next   = 1'b0;
                lead_next  = 1'b1;
                bad_next   = 1'b0;
                sig_next   = '0;
                cmp_next   = dtv_pkg::CMP_EQ;
                if (item.last_token)
                begin
                    list_bad_next = 1'b0;
                    count_next    = '0;
                end
                else
                begin
                    list_bad_next = !res.list_ok;
                    count_next    = res.token_count;
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg    <= 1'b1;
            neg_reg      <= 1'b0;
            lead_reg     <= 1'b1;
            bad_reg      <= 1'b0;
            sig_reg      <= '0;
            cmp_reg      <= dtv_pkg::CMP_EQ;
            list_bad_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            first_reg    <= first_next;
            neg_reg      <= neg_next;
            lead_reg     <= lead_next;
            bad_reg      <= bad_next;
            sig_reg      <= sig_next;
            cmp_reg      <= cmp_next;
            list_bad_reg <= list_bad_next;
            count_reg    <= count_next;
        end
    end

    // Checks
    `DTV_ASSERT_SAME(a_sig_range, clk, rst_n, 1'b1, sig_reg <= dtv_pkg::SIG_OVER, "digit count out of range")
    `DTV_ASSERT_SAME(a_cmp_code, clk, rst_n, 1'b1, cmp_reg != 2'd3, "unused compare code")
    `DTV_ASSERT_SAME(a_bad_token_list, clk, rst_n, res_valid && !res.token_ok, !res.list_ok, "bad token left list ok")
    `DTV_ASSERT_NEXT(a_list_clear, clk, rst_n, res_valid && res.list_end, (count_reg == '0) && !list_bad_reg, "list state not cleared")

endmodule

`default_nettype wire

// ===== design/dtv_out_reg.sv =====
// ----------------------------------------------------------------------------
// Decimal int32 token validator - result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dtv_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             res_valid,
    input  wire dtv_pkg::result_t res,
    output logic                  out_free,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output dtv_pkg::result_t      m_res
);

    logic             valid_reg;
    dtv_pkg::result_t res_reg;

    // Slot usable when empty or emptied this cycle
    assign out_free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire
